>>> rtl/core/mdwd_pkg.sv
// ----------------------------------------------------------------------------
// mdwd_pkg
// Shared widths, constants and the block position helper of the masked dB
// window decimator.
// ----------------------------------------------------------------------------
package mdwd_pkg;

  localparam int unsigned K_W        = 5;
  localparam int unsigned REDUCE_W   = 2;
  localparam int unsigned LINES_W    = 16;
  localparam int unsigned PIXELS_W   = 11;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned WEIGHT_W   = 8;
  localparam int unsigned DB_W       = 16;
  localparam int unsigned LOG_W      = 22;
  localparam int unsigned NEG_W      = 23;
  localparam int unsigned MAX_REDUCE = 3;

  localparam logic [22:0]        DB_TO_LOG2_Q32 = 23'd5573271;
  localparam logic [25:0]        LOG2_TO_DB_Q16 = 26'd50504453;
  localparam logic signed [23:0] LOG2_OFFSET    = 24'sd1966080;
  localparam logic signed [18:0] OUT_LOW        = -19'sd20480;
  localparam logic signed [18:0] OUT_HIGH       = 19'sd10240;

  typedef enum logic [1:0] {
    CFG_REDUCE = 2'd0,
    CFG_LINES  = 2'd1,
    CFG_PIXELS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             hit;
    logic             last;
    logic [POS_W-1:0] idx;
  } blk_t;

  // block grid centred in a line of n pixels, window k, stride 2^r
  function automatic blk_t block_at(input logic [POS_W-1:0] pos,
                                    input logic [POS_W-1:0] n,
                                    input logic [K_W-1:0] k,
                                    input logic [REDUCE_W-1:0] r);
    blk_t             ret;
    logic [POS_W-1:0] mask;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] nbm1;
    logic [POS_W-1:0] skip;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] off;
    ret   = '0;
    mask  = (POS_W'(1) << r) - POS_W'(1);
    span  = '0;
    nbm1  = '0;
    skip  = '0;
    start = '0;
    off   = '0;
    if (n >= POS_W'(k)) begin
      span  = n - POS_W'(k);
      nbm1  = span >> r;
      skip  = (span & mask) >> 1;
      start = skip + POS_W'(k) - POS_W'(1);
      if (pos >= start) begin
        off = pos - start;
        if (((off & mask) == '0) && ((off >> r) <= nbm1)) begin
          ret.hit  = 1'b1;
          ret.idx  = off >> r;
          ret.last = ((off >> r) == nbm1);
        end
      end
    end
    return ret;
  endfunction

endpackage

>>> rtl/core/mdwd_ram.sv
// ----------------------------------------------------------------------------
// mdwd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mdwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/masked_db_window_decimator.sv
// ----------------------------------------------------------------------------
// masked_db_window_decimator
// Weighted window mean of linear power over a row store, decimated on a
// centred block grid, result back in dB.
// ----------------------------------------------------------------------------
// A weight request or a pixel that closes no block is taken without leaving
// the idle state. A pixel that closes a block runs its window passes, the logs
// and control, all on one shared multiplier.
// One request in flight at a time; a finished result waits in the output
// register while the next request is taken.
// Reset: a root table build runs first, no requests are taken.
// Position counters clear; row and weight stores are undefined until written.
module masked_db_window_decimator
  import mdwd_pkg::*;
#(
  parameter int unsigned MAX_ROW_PIXELS = 1024,
  parameter int unsigned MAX_WINDOW     = 29
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [9:0]                          weight_index_i,
  input  logic [WEIGHT_W-1:0]                 weight_value_i,
  input  logic signed [DB_W-1:0]              pixel_db_i,
  input  logic                                pixel_missing_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [DB_W-1:0]              result_db_o,
  output logic                                result_missing_o,
  output logic [LINES_W-1:0]                  block_row_o,
  output logic [$clog2(MAX_ROW_PIXELS)-1:0]   block_col_o,
  output logic                                last_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]               cfg_data_i
);

  localparam int unsigned COL_W    = $clog2(MAX_ROW_PIXELS);
  localparam int unsigned SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned RS_DEPTH = MAX_WINDOW * MAX_ROW_PIXELS;
  localparam int unsigned RS_AW    = $clog2(RS_DEPTH);
  localparam int unsigned WS_DEPTH = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned WS_AW    = $clog2(WS_DEPTH);
  localparam int unsigned WSUM_W   = WEIGHT_W + WS_AW;
  localparam int unsigned SSUM_W   = WEIGHT_W + WS_AW + 31;

  typedef enum logic [14:0] {
    S_INIT    = 15'h0001,
    S_IDLE    = 15'h0002,
    S_CTR_RD  = 15'h0004,
    S_CTR_DAT = 15'h0008,
    S_P1_RD   = 15'h0010,
    S_P1_DAT  = 15'h0020,
    S_P1_END  = 15'h0040,
    S_P2_RD   = 15'h0080,
    S_P2_DAT  = 15'h0100,
    S_POW     = 15'h0200,
    S_ACC     = 15'h0400,
    S_NORM    = 15'h0800,
    S_SQR     = 15'h1000,
    S_FIN     = 15'h2000,
    S_DONE    = 15'h4000
  } state_e;

  function automatic logic [RS_AW-1:0] rs_addr(input logic [SLOT_W-1:0] slot,
                                               input logic [COL_W-1:0] col);
    return RS_AW'(slot) * RS_AW'(MAX_ROW_PIXELS) + RS_AW'(col);
  endfunction

  // control
  state_e               state_q, state_d;
  logic [REDUCE_W-1:0]  reduce_q, reduce_d;
  logic [LINES_W-1:0]   lines_q, lines_d;
  logic [PIXELS_W-1:0]  pixels_q, pixels_d;
  logic [LINES_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic                 out_valid_q, out_valid_d;
  logic [63:0]          sv_q, sv_d;
  logic [63:0]          sres_q, sres_d;
  logic [63:0]          sbit_q, sbit_d;
  logic [3:0]           sj_q, sj_d;

  // datapath
  logic [30:0]          root_q [16];
  logic [30:0]          root_d [16];
  logic [K_W-1:0]       k_q, k_d;
  logic [LINES_W-1:0]   brow_q, brow_d;
  logic [COL_W-1:0]     bcol_q, bcol_d;
  logic                 blast_q, blast_d;
  logic [RS_AW-1:0]     ctr_addr_q, ctr_addr_d;
  logic [SLOT_W-1:0]    wslot0_q, wslot0_d;
  logic [COL_W-1:0]     wcol0_q, wcol0_d;
  logic [SLOT_W-1:0]    it_slot_q, it_slot_d;
  logic [COL_W-1:0]     it_col_q, it_col_d;
  logic [K_W-1:0]       it_c_q, it_c_d;
  logic [K_W-1:0]       it_dd_q, it_dd_d;
  logic [WS_AW-1:0]     widx_q, widx_d;
  logic signed [DB_W-1:0] m_q, m_d;
  logic                 have_q, have_d;
  logic [WSUM_W-1:0]    wsum_q, wsum_d;
  logic [SSUM_W-1:0]    ssum_q, ssum_d;
  logic [WEIGHT_W-1:0]  w_q, w_d;
  logic [4:0]           ti_q, ti_d;
  logic [15:0]          tf_q, tf_d;
  logic [30:0]          p_q, p_d;
  logic [3:0]           j_q, j_d;
  logic [63:0]          lv_q, lv_d;
  logic [5:0]           ln_q, ln_d;
  logic [30:0]          lm_q, lm_d;
  logic [15:0]          frac_q, frac_d;
  logic [3:0]           step_q, step_d;
  logic                 log_sel_q, log_sel_d;
  logic [LOG_W-1:0]     logw_q, logw_d;
  logic [NEG_W-1:0]     neg_q, neg_d;
  logic [16:0]          delta_q, delta_d;
  logic signed [DB_W-1:0] res_db_q, res_db_d;
  logic                 res_miss_q, res_miss_d;
  logic signed [DB_W-1:0] o_db_q, o_db_d;
  logic                 o_miss_q, o_miss_d;
  logic [LINES_W-1:0]   o_row_q, o_row_d;
  logic [COL_W-1:0]     o_col_q, o_col_d;
  logic                 o_last_q, o_last_d;

  // memories
  logic                 rs_we;
  logic [RS_AW-1:0]     rs_waddr, rs_raddr;
  logic [16:0]          rs_rdata;
  logic                 ws_we;
  logic [WS_AW-1:0]     ws_waddr;
  logic [WEIGHT_W-1:0]  ws_rdata;

  // shared multiplier
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_p;

  // frame geometry
  logic [REDUCE_W-1:0]  r_eff;
  logic [K_W-1:0]       k_eff, half_eff;
  logic [POS_W-1:0]     nl, np;
  logic                 wrap;
  logic [LINES_W-1:0]   y;
  logic [COL_W-1:0]     x;
  logic [SLOT_W-1:0]    ys;
  blk_t                 rb, cb;
  logic [SLOT_W:0]      ctr_slot_t, w_slot_t;
  logic [SLOT_W-1:0]    ctr_slot, w_slot;

  // iteration
  logic                 it_last;
  logic [SLOT_W-1:0]    slot_inc;

  logic                 e_miss;
  logic signed [DB_W-1:0] e_val;
  logic signed [16:0]   d_s;

  assign e_miss = rs_rdata[16];
  assign e_val  = rs_rdata[15:0];
  assign d_s    = {m_q[DB_W-1], m_q} - {e_val[DB_W-1], e_val};

  always_comb begin
    r_eff = reduce_q;
    if (r_eff == '0) begin
      r_eff = REDUCE_W'(1);
    end
    if (32'(r_eff) > MAX_REDUCE) begin
      r_eff = REDUCE_W'(MAX_REDUCE);
    end
    for (int i = 0; i < 2; i++) begin
      if ((r_eff > REDUCE_W'(1)) && (((32'd4 << r_eff) - 32'd3) > MAX_WINDOW)) begin
        r_eff = r_eff - REDUCE_W'(1);
      end
    end
    k_eff    = K_W'((32'd4 << r_eff) - 32'd3);
    half_eff = (k_eff - K_W'(1)) >> 1;
  end

  always_comb begin
    nl = (lines_q == '0) ? POS_W'(1) : POS_W'(lines_q);
    np = (pixels_q == '0) ? POS_W'(1) : POS_W'(pixels_q);
    if (np > POS_W'(MAX_ROW_PIXELS)) begin
      np = POS_W'(MAX_ROW_PIXELS);
    end
    wrap = (POS_W'(row_q) >= nl) || (POS_W'(col_q) >= np);
    y    = wrap ? '0 : row_q;
    x    = wrap ? '0 : col_q;
    ys   = wrap ? '0 : slot_q;
    rb   = block_at(POS_W'(y), nl, k_eff, r_eff);
    cb   = block_at(POS_W'(x), np, k_eff, r_eff);
    ctr_slot_t = {1'b0, ys} + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(half_eff);
    w_slot_t   = {1'b0, ys} + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(k_eff - K_W'(1));
    if (ctr_slot_t >= (SLOT_W+1)'(MAX_WINDOW)) begin
      ctr_slot_t = ctr_slot_t - (SLOT_W+1)'(MAX_WINDOW);
    end
    if (w_slot_t >= (SLOT_W+1)'(MAX_WINDOW)) begin
      w_slot_t = w_slot_t - (SLOT_W+1)'(MAX_WINDOW);
    end
    ctr_slot = ctr_slot_t[SLOT_W-1:0];
    w_slot   = w_slot_t[SLOT_W-1:0];
  end

  assign it_last  = (it_c_q == k_q - K_W'(1)) && (it_dd_q == k_q - K_W'(1));
  assign slot_inc = (32'(it_slot_q) == MAX_WINDOW - 1) ? '0 : it_slot_q + SLOT_W'(1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_P2_DAT: begin
        mul_a = 32'(d_s[15:0]);
        mul_b = 32'(DB_TO_LOG2_Q32);
      end
      S_POW: begin
        mul_a = 32'(p_q);
        mul_b = 32'(root_q[j_q]);
      end
      S_ACC: begin
        mul_a = 32'(w_q);
        mul_b = 32'(p_q >> ti_q);
      end
      S_SQR: begin
        mul_a = 32'(lm_q);
        mul_b = 32'(lm_q);
      end
      S_FIN: begin
        mul_a = 32'(neg_q);
        mul_b = 32'(LOG2_TO_DB_Q16);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    logic [63:0]          cand;
    logic [63:0]          sv_n;
    logic [63:0]          sres_n;
    logic                 adv;
    logic [39:0]          t;
    logic [63:0]          rnd;
    logic [31:0]          sq;
    logic [15:0]          frac_n;
    logic [LOG_W-1:0]     logv;
    logic signed [23:0]   neg_s;
    logic signed [18:0]   v;

    state_d     = state_q;
    reduce_d    = reduce_q;
    lines_d     = lines_q;
    pixels_d    = pixels_q;
    row_d       = row_q;
    col_d       = col_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    sv_d        = sv_q;
    sres_d      = sres_q;
    sbit_d      = sbit_q;
    sj_d        = sj_q;
    root_d      = root_q;
    k_d         = k_q;
    brow_d      = brow_q;
    bcol_d      = bcol_q;
    blast_d     = blast_q;
    ctr_addr_d  = ctr_addr_q;
    wslot0_d    = wslot0_q;
    wcol0_d     = wcol0_q;
    it_slot_d   = it_slot_q;
    it_col_d    = it_col_q;
    it_c_d      = it_c_q;
    it_dd_d     = it_dd_q;
    widx_d      = widx_q;
    m_d         = m_q;
    have_d      = have_q;
    wsum_d      = wsum_q;
    ssum_d      = ssum_q;
    w_d         = w_q;
    ti_d        = ti_q;
    tf_d        = tf_q;
    p_d         = p_q;
    j_d         = j_q;
    lv_d        = lv_q;
    ln_d        = ln_q;
    lm_d        = lm_q;
    frac_d      = frac_q;
    step_d      = step_q;
    log_sel_d   = log_sel_q;
    logw_d      = logw_q;
    neg_d       = neg_q;
    delta_d     = delta_q;
    res_db_d    = res_db_q;
    res_miss_d  = res_miss_q;
    o_db_d      = o_db_q;
    o_miss_d    = o_miss_q;
    o_row_d     = o_row_q;
    o_col_d     = o_col_q;
    o_last_d    = o_last_q;
    rs_we       = 1'b0;
    rs_waddr    = rs_addr(ys, x);
    rs_raddr    = (state_q == S_CTR_RD) ? ctr_addr_q : rs_addr(it_slot_q, it_col_q);
    ws_we       = 1'b0;
    ws_waddr    = WS_AW'(weight_index_i);
    cand        = sres_q + sbit_q;
    sv_n        = sv_q;
    sres_n      = sres_q >> 1;
    adv         = 1'b0;
    t           = mul_p[39:0];
    rnd         = '0;
    sq          = mul_p[61:30];
    frac_n      = {frac_q[14:0], sq[31]};
    logv        = {ln_q, frac_n};
    neg_s       = '0;
    v           = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_REDUCE: reduce_d = cfg_data_i[REDUCE_W-1:0];
        CFG_LINES:  lines_d  = cfg_data_i[LINES_W-1:0];
        CFG_PIXELS: pixels_d = cfg_data_i[PIXELS_W-1:0];
        default: begin
        end
      endcase
    end

    unique case (state_q)
      S_INIT: begin
        if (sv_q >= cand) begin
          sv_n   = sv_q - cand;
          sres_n = (sres_q >> 1) + sbit_q;
        end
        if (sbit_q[0]) begin
          root_d[sj_q] = sres_n[30:0];
          sv_d   = sres_n << 30;
          sres_d = '0;
          sbit_d = 64'h4000_0000_0000_0000;
          sj_d   = sj_q + 4'd1;
          if (sj_q == 4'd15) begin
            state_d = S_IDLE;
          end
        end else begin
          sv_d   = sv_n;
          sres_d = sres_n;
          sbit_d = sbit_q >> 2;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            ws_we = (32'(weight_index_i) < WS_DEPTH);
          end else begin
            rs_we = 1'b1;
            if (POS_W'(x) + POS_W'(1) >= np) begin
              col_d = '0;
              if (POS_W'(y) + POS_W'(1) >= nl) begin
                row_d  = '0;
                slot_d = '0;
              end else begin
                row_d  = y + LINES_W'(1);
                slot_d = (32'(ys) == MAX_WINDOW - 1) ? '0 : ys + SLOT_W'(1);
              end
            end else begin
              row_d  = y;
              slot_d = ys;
              col_d  = x + COL_W'(1);
            end
            if (rb.hit && cb.hit) begin
              k_d        = k_eff;
              brow_d     = rb.idx[LINES_W-1:0];
              bcol_d     = cb.idx[COL_W-1:0];
              blast_d    = rb.last && cb.last;
              ctr_addr_d = rs_addr(ctr_slot, x - COL_W'(half_eff));
              wslot0_d   = w_slot;
              wcol0_d    = x - COL_W'(k_eff - K_W'(1));
              it_slot_d  = w_slot;
              it_col_d   = x - COL_W'(k_eff - K_W'(1));
              it_c_d     = '0;
              it_dd_d    = '0;
              widx_d     = '0;
              state_d    = S_CTR_RD;
            end
          end
        end
      end
      S_CTR_RD: begin
        state_d = S_CTR_DAT;
      end
      S_CTR_DAT: begin
        if (e_miss) begin
          res_miss_d = 1'b1;
          res_db_d   = '0;
          state_d    = S_DONE;
        end else begin
          have_d  = 1'b0;
          m_d     = '0;
          wsum_d  = '0;
          state_d = S_P1_RD;
        end
      end
      S_P1_RD: begin
        state_d = S_P1_DAT;
      end
      S_P1_DAT: begin
        if (!e_miss && (ws_rdata != '0)) begin
          if (!have_q || (e_val > m_q)) begin
            m_d = e_val;
          end
          have_d = 1'b1;
          wsum_d = wsum_q + WSUM_W'(ws_rdata);
        end
        if (it_last) begin
          state_d = S_P1_END;
        end else begin
          adv     = 1'b1;
          state_d = S_P1_RD;
        end
      end
      S_P1_END: begin
        if (wsum_q == '0) begin
          res_miss_d = 1'b1;
          res_db_d   = '0;
          state_d    = S_DONE;
        end else begin
          it_slot_d = wslot0_q;
          it_col_d  = wcol0_q;
          it_c_d    = '0;
          it_dd_d   = '0;
          widx_d    = '0;
          ssum_d    = '0;
          state_d   = S_P2_RD;
        end
      end
      S_P2_RD: begin
        state_d = S_P2_DAT;
      end
      S_P2_DAT: begin
        w_d = ws_rdata;
        if (!e_miss && (ws_rdata != '0) && !d_s[16] && (t[39:32] < 8'd31)) begin
          ti_d    = t[36:32];
          tf_d    = t[31:16];
          p_d     = 31'h4000_0000;
          j_d     = '0;
          state_d = S_POW;
        end else if (it_last) begin
          lv_d      = 64'(wsum_q);
          ln_d      = 6'd63;
          log_sel_d = 1'b0;
          state_d   = S_NORM;
        end else begin
          adv     = 1'b1;
          state_d = S_P2_RD;
        end
      end
      S_POW: begin
        if (tf_q[4'd15 - j_q]) begin
          rnd = mul_p + (64'd1 << 29);
          p_d = rnd[60:30];
        end
        j_d = j_q + 4'd1;
        if (j_q == 4'd15) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        ssum_d = ssum_q + SSUM_W'(mul_p);
        if (it_last) begin
          lv_d      = 64'(wsum_q);
          ln_d      = 6'd63;
          log_sel_d = 1'b0;
          state_d   = S_NORM;
        end else begin
          adv     = 1'b1;
          state_d = S_P2_RD;
        end
      end
      S_NORM: begin
        if ((ln_q != '0) && !lv_q[63]) begin
          lv_d = lv_q << 1;
          ln_d = ln_q - 6'd1;
        end else begin
          lm_d    = lv_q[63:33];
          frac_d  = '0;
          step_d  = '0;
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        lm_d   = sq[31] ? sq[31:1] : sq[30:0];
        frac_d = frac_n;
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          if (!log_sel_q) begin
            logw_d    = logv;
            lv_d      = 64'(ssum_q);
            ln_d      = 6'd63;
            log_sel_d = 1'b1;
            state_d   = S_NORM;
          end else begin
            neg_s   = $signed({2'b00, logw_q}) + LOG2_OFFSET - $signed({2'b00, logv});
            neg_d   = neg_s[23] ? '0 : neg_s[NEG_W-1:0];
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (log_sel_q) begin
          rnd       = mul_p + 64'h8000_0000;
          delta_d   = rnd[48:32];
          log_sel_d = 1'b0;
        end else begin
          v = $signed({{3{m_q[DB_W-1]}}, m_q}) - $signed({2'b00, delta_q});
          if (v < OUT_LOW) begin
            v = OUT_LOW;
          end
          if (v > OUT_HIGH) begin
            v = OUT_HIGH;
          end
          res_db_d   = v[DB_W-1:0];
          res_miss_d = 1'b0;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          o_db_d      = res_db_q;
          o_miss_d    = res_miss_q;
          o_row_d     = brow_q;
          o_col_d     = bcol_q;
          o_last_d    = blast_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (adv) begin
      widx_d = widx_q + WS_AW'(1);
      if (it_dd_q == k_q - K_W'(1)) begin
        it_dd_d   = '0;
        it_c_d    = it_c_q + K_W'(1);
        it_col_d  = wcol0_q;
        it_slot_d = slot_inc;
      end else begin
        it_dd_d  = it_dd_q + K_W'(1);
        it_col_d = it_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      reduce_q    <= REDUCE_W'(1);
      lines_q     <= LINES_W'(29);
      pixels_q    <= PIXELS_W'(29);
      row_q       <= '0;
      col_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      sv_q        <= 64'h0800_0000_0000_0000;
      sres_q      <= '0;
      sbit_q      <= 64'h4000_0000_0000_0000;
      sj_q        <= '0;
      log_sel_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      reduce_q    <= reduce_d;
      lines_q     <= lines_d;
      pixels_q    <= pixels_d;
      row_q       <= row_d;
      col_q       <= col_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      sv_q        <= sv_d;
      sres_q      <= sres_d;
      sbit_q      <= sbit_d;
      sj_q        <= sj_d;
      log_sel_q   <= log_sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q     <= root_d;
    k_q        <= k_d;
    brow_q     <= brow_d;
    bcol_q     <= bcol_d;
    blast_q    <= blast_d;
    ctr_addr_q <= ctr_addr_d;
    wslot0_q   <= wslot0_d;
    wcol0_q    <= wcol0_d;
    it_slot_q  <= it_slot_d;
    it_col_q   <= it_col_d;
    it_c_q     <= it_c_d;
    it_dd_q    <= it_dd_d;
    widx_q     <= widx_d;
    m_q        <= m_d;
    have_q     <= have_d;
    wsum_q     <= wsum_d;
    ssum_q     <= ssum_d;
    w_q        <= w_d;
    ti_q       <= ti_d;
    tf_q       <= tf_d;
    p_q        <= p_d;
    j_q        <= j_d;
    lv_q       <= lv_d;
    ln_q       <= ln_d;
    lm_q       <= lm_d;
    frac_q     <= frac_d;
    step_q     <= step_d;
    logw_q     <= logw_d;
    neg_q      <= neg_d;
    delta_q    <= delta_d;
    res_db_q   <= res_db_d;
    res_miss_q <= res_miss_d;
    o_db_q     <= o_db_d;
    o_miss_q   <= o_miss_d;
    o_row_q    <= o_row_d;
    o_col_q    <= o_col_d;
    o_last_q   <= o_last_d;
  end

  mdwd_ram #(
    .WIDTH (17),
    .DEPTH (RS_DEPTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i ({pixel_missing_i, pixel_db_i}),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rdata)
  );

  mdwd_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (WS_DEPTH)
  ) u_weight_store (
    .clk_i   (clk_i),
    .we_i    (ws_we),
    .waddr_i (ws_waddr),
    .wdata_i (weight_value_i),
    .raddr_i (widx_q),
    .rdata_o (ws_rdata)
  );

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_db_o      = o_db_q;
  assign result_missing_o = o_miss_q;
  assign block_row_o      = o_row_q;
  assign block_col_o      = o_col_q;
  assign last_o           = o_last_q;

endmodule
